[rtl/ctli_pkg.sv]
`timescale 1ns / 1ps
package ctli_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   localparam int VAL_W       = 32;
   localparam int IDX_W       = 8;
   localparam int SCALE_W     = 32;
   localparam int REQ_DATA_W  = 72;
   localparam int CSR_IDX_W   = 2;

   localparam int D_W         = VAL_W + 2;
   localparam int TP_W        = D_W + SCALE_W + 1;
   localparam int T_W         = 49;
   localparam int FRAC_W      = T_W;
   localparam int FL_W        = 24;
   localparam int FH_W        = FRAC_W - FL_W;
   localparam int SD_W        = VAL_W + 1;
   localparam int PH_W        = SD_W + FH_W;
   localparam int PL_W        = SD_W + FL_W + 1;
   localparam int P_W         = PH_W + FL_W;
   localparam int Q_W         = P_W - 16;
   localparam int SUM_W       = Q_W + 1;

   localparam logic OP_EVAL  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_X      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_INDEX = 2'd2;

   localparam logic [VAL_W-1:0]   MIN_X_RESET      = 32'h0000_0000;
   localparam logic [SCALE_W-1:0] SCALE_RESET      = 32'h00FF_0000;
   localparam logic [IDX_W-1:0]   LAST_INDEX_RESET = 8'd255;

   localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

   typedef struct packed {
      logic s4;
      logic s5;
      logic s6;
   } blend_en_type;

endpackage

[rtl/ctli_blend.sv]
`timescale 1ns / 1ps
module ctli_blend (
   input  logic                                clock,
   input  ctli_pkg::blend_en_type              en,
   input  logic                                op,
   input  logic signed [ctli_pkg::VAL_W-1:0]   s0,
   input  logic signed [ctli_pkg::VAL_W-1:0]   s1,
   input  logic signed [ctli_pkg::FRAC_W-1:0]  frac,
   output logic        [ctli_pkg::VAL_W-1:0]   value,
   output logic                                saturated
);
   import ctli_pkg::*;

   logic signed [SD_W-1:0]  sd;
   logic signed [FH_W-1:0]  fh;
   logic        [FL_W-1:0]  fl;
   logic signed [PH_W-1:0]  ph_ff;
   logic signed [PL_W-1:0]  pl_ff;
   logic signed [VAL_W-1:0] s0_4_ff;
   logic                    op4_ff;

   logic signed [P_W-1:0]   p_sum;
   logic signed [Q_W-1:0]   q_ff;
   logic signed [VAL_W-1:0] s0_5_ff;
   logic                    op5_ff;

   logic signed [SUM_W-1:0] total;
   logic                    over;
   logic [VAL_W-1:0]        value_ff;
   logic                    sat_ff;

   assign sd = SD_W'(s1) - SD_W'(s0);
   assign fh = frac[FRAC_W-1:FL_W];
   assign fl = frac[FL_W-1:0];

   always_ff @(posedge clock) begin
      if (en.s4) begin
         ph_ff   <= sd * fh;
         pl_ff   <= sd * $signed({1'b0, fl});
         s0_4_ff <= s0;
         op4_ff  <= op;
      end
   end

   assign p_sum = $signed({ph_ff, {FL_W{1'b0}}}) + P_W'(pl_ff);

   // floor of the product over 2^16
   always_ff @(posedge clock) begin
      if (en.s5) begin
         q_ff    <= p_sum[P_W-1:16];
         s0_5_ff <= s0_4_ff;
         op5_ff  <= op4_ff;
      end
   end

   assign total = SUM_W'(s0_5_ff) + SUM_W'(q_ff);
   assign over  = !((&total[SUM_W-1:VAL_W-1]) || !(|total[SUM_W-1:VAL_W-1]));

   always_ff @(posedge clock) begin
      if (en.s6) begin
         if (op5_ff == OP_WRITE) begin
            value_ff <= '0;
            sat_ff   <= 1'b0;
         end else if (over) begin
            value_ff <= total[SUM_W-1] ? VAL_MIN : VAL_MAX;
            sat_ff   <= 1'b1;
         end else begin
            value_ff <= total[VAL_W-1:0];
            sat_ff   <= 1'b0;
         end
      end
   end

   assign value     = value_ff;
   assign saturated = sat_ff;

endmodule

[rtl/curve_table_linear_interpolator.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tuser opcode; tdata position, entry_index, entry_value
// rsp       out        rsp_tvalid/rsp_tready  tuser saturated; tdata value
// csr       in         csr_valid/csr_ready    csr_index register, csr_data value
//
// One transaction per cycle unless rsp_tready stalls the output; results leave from the stage 6 registers.
// Stage 3 owns the sample memory: one write and two registered reads per cycle while stage 3 is enabled.
// Reset clears stage valids and the CSR registers; the sample memory is not cleared.
// rsp_tready low holds the output; bubbles ahead of it fill, then req_tready drops.
module curve_table_linear_interpolator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ctli_pkg::REQ_DATA_W-1:0]      req_tdata,  // position, entry_index, entry_value
   input  logic                                 req_tuser,  // opcode
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ctli_pkg::VAL_W-1:0]           rsp_tdata,  // value
   output logic                                 rsp_tuser,  // saturated
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ctli_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ctli_pkg::VAL_W-1:0]           csr_data
);
   import ctli_pkg::*;

   logic [VAL_W-1:0]   min_x_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [IDX_W-1:0]   last_index_ff;

   logic [6:1] vld_ff;
   logic [6:1] en;

   logic [VAL_W-1:0] req_position;
   logic [IDX_W-1:0] req_entry_index;
   logic [VAL_W-1:0] req_entry_value;

   logic                   op1_ff;
   logic signed [D_W-1:0]  d1_ff;
   logic [IDX_W-1:0]       idx1_ff;
   logic [VAL_W-1:0]       val1_ff;

   logic                   op2_ff;
   logic signed [TP_W-1:0] tp2_ff;
   logic [IDX_W-1:0]       idx2_ff;
   logic [VAL_W-1:0]       val2_ff;

   logic signed [T_W-1:0]  t3;
   logic                   t_pos;
   logic [VAL_W-1:0]       t_whole;
   logic [IDX_W-1:0]       i0;
   logic [IDX_W-1:0]       i1;
   logic signed [FRAC_W-1:0] frac3;

   logic [VAL_W-1:0]       mem [TABLE_DEPTH];
   logic [VAL_W-1:0]       rd0_ff;
   logic [VAL_W-1:0]       rd1_ff;
   logic                   ok0_ff;
   logic                   ok1_ff;
   logic                   op3_ff;
   logic signed [FRAC_W-1:0] frac3_ff;

   logic signed [VAL_W-1:0] s0;
   logic signed [VAL_W-1:0] s1;
   blend_en_type            blend_en;

   assign req_position    = req_tdata[31:0];
   assign req_entry_index = req_tdata[39:32];
   assign req_entry_value = req_tdata[71:40];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff      <= MIN_X_RESET;
         scale_ff      <= SCALE_RESET;
         last_index_ff <= LAST_INDEX_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MIN_X:      min_x_ff      <= csr_data;
            REG_SCALE:      scale_ff      <= csr_data;
            REG_LAST_INDEX: last_index_ff <= csr_data[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      en[6] = !vld_ff[6] || rsp_tready;
      for (int k = 5; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[1]) vld_ff[1] <= req_tvalid;
         for (int k = 2; k <= 6; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         op1_ff  <= req_tuser;
         d1_ff   <= $signed({{2{req_position[VAL_W-1]}}, req_position})
                    - $signed({{2{min_x_ff[VAL_W-1]}}, min_x_ff});
         idx1_ff <= req_entry_index;
         val1_ff <= req_entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         op2_ff  <= op1_ff;
         tp2_ff  <= d1_ff * $signed({1'b0, scale_ff});
         idx2_ff <= idx1_ff;
         val2_ff <= val1_ff;
      end
   end

   assign t3      = tp2_ff[T_W+15:16];
   assign t_pos   = !t3[T_W-1] && (t3 != '0);
   assign t_whole = t3[T_W-2:16];

   always_comb begin
      if (!t_pos) begin
         i0 = '0;
      end else if (t_whole > VAL_W'(last_index_ff)) begin
         i0 = last_index_ff;
      end else begin
         i0 = t_whole[IDX_W-1:0];
      end
      i1 = (i0 < last_index_ff) ? i0 + 1'b1 : last_index_ff;
   end

   assign frac3 = t3 - $signed(T_W'({i0, 16'h0000}));

   always_ff @(posedge clock) begin
      if (en[3] && vld_ff[2] && op2_ff == OP_WRITE && int'(idx2_ff) < TABLE_DEPTH) begin
         mem[ADDR_W'(idx2_ff)] <= val2_ff;
      end
      if (en[3]) begin
         rd0_ff   <= mem[ADDR_W'(i0)];
         rd1_ff   <= mem[ADDR_W'(i1)];
         ok0_ff   <= int'(i0) < TABLE_DEPTH;
         ok1_ff   <= int'(i1) < TABLE_DEPTH;
         op3_ff   <= op2_ff;
         frac3_ff <= frac3;
      end
   end

   assign s0 = ok0_ff ? $signed(rd0_ff) : '0;
   assign s1 = ok1_ff ? $signed(rd1_ff) : '0;

   assign blend_en = '{s4: en[4], s5: en[5], s6: en[6]};

   ctli_blend u_blend (
      .clock     (clock),
      .en        (blend_en),
      .op        (op3_ff),
      .s0        (s0),
      .s1        (s1),
      .frac      (frac3_ff),
      .value     (rsp_tdata),
      .saturated (rsp_tuser)
   );

   assign rsp_tvalid = vld_ff[6];

endmodule

[rtl/ctli_checker.sv]
`timescale 1ns / 1ps
module ctli_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [ctli_pkg::VAL_W-1:0]  rsp_tdata,
   input logic                        rsp_tuser
);
   import ctli_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response transaction changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == VAL_MAX || rsp_tdata == VAL_MIN)
      else $error("saturated flag without a clamped value");

endmodule

bind curve_table_linear_interpolator ctli_checker u_ctli_checker (.*);
